/* rtl/assert_macros.svh */
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("check failed");
`define CHK_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("check failed");
`endif

/* rtl/iatp_pkg.sv */
package iatp_pkg;
  localparam int unsigned MaxTick = 255;
  localparam int unsigned InW = 40;
  localparam int unsigned OutW = 32;

  typedef enum logic [3:0] {
    OP_READ = 4'd0, OP_WRITE = 4'd1, OP_TICK = 4'd2, OP_PINS_A = 4'd3,
    OP_PINS_B = 4'd4, OP_CA1 = 4'd5, OP_CA2 = 4'd6, OP_CB1 = 4'd7, OP_CB2 = 4'd8
  } op_e;

  // bus register numbers
  localparam logic [3:0] RegOrb = 4'd0, RegOra = 4'd1, RegDdrb = 4'd2, RegDdra = 4'd3;
  localparam logic [3:0] RegT1cl = 4'd4, RegT1ch = 4'd5, RegT1ll = 4'd6, RegT1lh = 4'd7;
  localparam logic [3:0] RegT2cl = 4'd8, RegT2ch = 4'd9, RegSr = 4'd10, RegAcr = 4'd11;
  localparam logic [3:0] RegPcr = 4'd12, RegIfr = 4'd13, RegIer = 4'd14, RegOraNh = 4'd15;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_MOD, ST_FIN, ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture word
    logic exec;     // apply item
    logic mod_start;
    logic mod_step;
    logic fin;      // finish free-run reload
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_mod;
    logic mod_done;
  } sts_t;
endpackage

/* rtl/interface_adapter_timers_ports.sv */
// channel   | dir | tdata fields (low bit up)
// s_axis    | in  | opcode[3:0] reg_index[7:4] write_data[15:8] pin_value[23:16]
//           |     | line_level[24] cycles[32:25], zero to bit 39
// m_axis    | out | read_data[7:0] irq[8] port_a_out[16:9] port_b_out[24:17]
//           |     | port_a_changed[25] port_b_changed[26], zero to bit 31
// One word at a time: accept, execute, then result; a tick that expires
// free-running timer 1 adds an 8-step restoring modulo on the overshoot and a
// reload step before the output state, which offers the result. Input is
// taken again the cycle after the result is taken.
// Reset (async, rst_ni low) sets all registers to their reset values; a stalled result holds.
module interface_adapter_timers_ports (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // opcode, reg_index, write_data, pin_value, line_level, cycles
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // read_data, irq, port_a_out, port_b_out, a_changed, b_changed
);
  iatp_pkg::cmd_t cmd;
  iatp_pkg::sts_t sts;
  logic [iatp_pkg::InW-1:0] word;

  // repack cycles to the datapath's byte-aligned slot
  assign word = {s_axis_tdata[32:25], 7'd0, s_axis_tdata[24:0]};

  iatp_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  iatp_dp u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_word_i(word),
    .cmd_i(cmd), .sts_o(sts), .out_word_o(m_axis_tdata)
  );
endmodule

/* rtl/iatp_ctrl.sv */
module iatp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  iatp_pkg::sts_t   sts_i,
  output iatp_pkg::cmd_t   cmd_o
);
  iatp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= iatp_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      iatp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = iatp_pkg::ST_EXEC;
        end
      end
      iatp_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.need_mod) begin
          cmd_o.mod_start = 1'b1;
          state_d = iatp_pkg::ST_MOD;
        end else state_d = iatp_pkg::ST_OUT;
      end
      iatp_pkg::ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_done) state_d = iatp_pkg::ST_FIN;
      end
      iatp_pkg::ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d = iatp_pkg::ST_OUT;
      end
      iatp_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = iatp_pkg::ST_IDLE;
      end
      default: state_d = iatp_pkg::ST_IDLE;
    endcase
  end
endmodule

/* rtl/iatp_dp.sv */
module iatp_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [iatp_pkg::InW-1:0]      in_word_i,
  input  iatp_pkg::cmd_t                cmd_i,
  output iatp_pkg::sts_t                sts_o,
  output logic [iatp_pkg::OutW-1:0]     out_word_o
);
  localparam logic [6:0] FCa2 = 7'h01, FCa1 = 7'h02, FSr = 7'h04, FCb2 = 7'h08;
  localparam logic [6:0] FCb1 = 7'h10, FT2 = 7'h20, FT1 = 7'h40;
  localparam logic [16:0] CntIdle = 17'h10000;

  logic [iatp_pkg::InW-1:0] in_q;
  logic [7:0] ora_q, orb_q, dda_q, ddb_q, pa_q, pb_q, acr_q, pcr_q, sr_q, rd_q;
  logic [15:0] l1_q, l2_q;
  logic [16:0] c1_q, c2_q;
  logic a1_q, a2_q, pb7_q, cha_q, chb_q;
  logic [6:0] ifr_q, ier_q;
  logic [3:0] lines_q;
  // modulo unit: after % period, one quotient bit per step
  logic [7:0] rem_q, quo_q;
  logic [16:0] per_q;
  logic [3:0] bit_q;

  logic [3:0] op, ri;
  logic [7:0] wd, pv, cy;
  logic lv;
  assign op = in_q[3:0];
  assign ri = in_q[7:4];
  assign wd = in_q[15:8];
  assign pv = in_q[23:16];
  assign lv = in_q[24];
  assign cy = in_q[39:32];

  function automatic logic [6:0] clr_a(input logic [6:0] f, input logic [7:0] pcr);
    logic [6:0] r;
    r = f & ~FCa1;
    if ((pcr & 8'h0a) != 8'h02) r = r & ~FCa2;
    return r;
  endfunction
  function automatic logic [6:0] clr_b(input logic [6:0] f, input logic [7:0] pcr);
    logic [6:0] r;
    r = f & ~FCb1;
    if ((pcr & 8'ha0) != 8'h20) r = r & ~FCb2;
    return r;
  endfunction

  logic [7:0] pina, pinb, rdv;
  logic [16:0] c1m, c2m, t1after;
  logic [16:0] n17;
  logic t1_exp, cha_set, chb_set;
  assign pina = (pa_q & ~dda_q) | (ora_q & dda_q);
  assign pinb = (pb_q & ~ddb_q) | (orb_q & ddb_q);
  assign c1m = c1_q - 17'd1;
  assign c2m = c2_q - 17'd1;
  assign n17 = {9'd0, cy};
  assign t1after = n17 - c1_q;
  assign t1_exp = (cy != 8'd0) && a1_q && (n17 >= c1_q);
  assign sts_o.need_mod = (op == iatp_pkg::OP_TICK) && t1_exp && acr_q[6];
  assign sts_o.mod_done = (bit_q == 4'd0);

  // which items re-report the port outputs
  assign cha_set = (op == iatp_pkg::OP_WRITE) &&
                   (ri == iatp_pkg::RegOra || ri == iatp_pkg::RegOraNh ||
                    ri == iatp_pkg::RegDdra);
  assign chb_set = ((op == iatp_pkg::OP_WRITE) &&
                    (ri == iatp_pkg::RegOrb || ri == iatp_pkg::RegDdrb ||
                     ri == iatp_pkg::RegAcr || (ri == iatp_pkg::RegT1ch && acr_q[7]))) ||
                   ((op == iatp_pkg::OP_TICK) && t1_exp && !acr_q[6] && acr_q[7]);

  always_comb begin
    case (ri)
      iatp_pkg::RegOrb: rdv = acr_q[7] ? {pb7_q, pinb[6:0]} : pinb;
      iatp_pkg::RegOra: rdv = pina;
      iatp_pkg::RegDdrb: rdv = ddb_q;
      iatp_pkg::RegDdra: rdv = dda_q;
      iatp_pkg::RegT1cl: rdv = c1m[7:0];
      iatp_pkg::RegT1ch: rdv = c1m[15:8];
      iatp_pkg::RegT1ll: rdv = l1_q[7:0];
      iatp_pkg::RegT1lh: rdv = l1_q[15:8];
      iatp_pkg::RegT2cl: rdv = c2m[7:0];
      iatp_pkg::RegT2ch: rdv = c2m[15:8];
      iatp_pkg::RegSr: rdv = sr_q;
      iatp_pkg::RegAcr: rdv = acr_q;
      iatp_pkg::RegPcr: rdv = pcr_q;
      iatp_pkg::RegIfr: rdv = {|(ifr_q & ier_q), ifr_q};
      iatp_pkg::RegIer: rdv = {1'b1, ier_q};
      default: rdv = pina;
    endcase
  end

  // trial subtract for restoring division of rem by period
  logic [24:0] trial;
  logic [16:0] newcnt;
  assign trial = {17'd0, rem_q} - ({8'd0, per_q} << bit_q[2:0]);
  assign newcnt = per_q - {9'd0, rem_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ora_q <= '0; orb_q <= '0; dda_q <= '0; ddb_q <= '0;
      pa_q <= 8'hff; pb_q <= 8'hff; l1_q <= 16'hffff; l2_q <= 16'hffff;
      c1_q <= CntIdle; c2_q <= CntIdle; a1_q <= 1'b0; a2_q <= 1'b0;
      ifr_q <= '0; ier_q <= '0; acr_q <= '0; pcr_q <= '0; sr_q <= '0;
      pb7_q <= 1'b0; lines_q <= '0; rd_q <= '0; cha_q <= 1'b0; chb_q <= 1'b0;
      rem_q <= '0; quo_q <= '0; per_q <= '0; bit_q <= '0; in_q <= '0;
    end else begin
      if (cmd_i.load) in_q <= in_word_i;
      if (cmd_i.mod_start) begin
        rem_q <= t1after[7:0];
        quo_q <= '0;
        per_q <= {1'b0, l1_q} + 17'd1;
        bit_q <= 4'd7;
      end
      if (cmd_i.mod_step) begin
        if (!trial[24]) begin
          rem_q <= trial[7:0];
          quo_q <= quo_q | (8'd1 << bit_q[2:0]);
        end
        if (bit_q != 4'd0) bit_q <= bit_q - 4'd1;
      end
      if (cmd_i.fin) begin
        c1_q <= newcnt;
        // unders = 1 + quotient; toggle when odd, i.e. quotient even
        if (acr_q[7] && !quo_q[0]) begin
          pb7_q <= ~pb7_q;
          chb_q <= 1'b1;
        end
      end
      if (cmd_i.exec) begin
        rd_q <= (op == iatp_pkg::OP_READ) ? rdv : 8'd0;
        cha_q <= cha_set;
        chb_q <= chb_set;
        case (op)
          iatp_pkg::OP_READ: begin
            case (ri)
              iatp_pkg::RegOrb: ifr_q <= clr_b(ifr_q, pcr_q);
              iatp_pkg::RegOra: ifr_q <= clr_a(ifr_q, pcr_q);
              iatp_pkg::RegT1cl: ifr_q <= ifr_q & ~FT1;
              iatp_pkg::RegT2cl: ifr_q <= ifr_q & ~FT2;
              iatp_pkg::RegSr: ifr_q <= ifr_q & ~FSr;
              default: ;
            endcase
          end
          iatp_pkg::OP_WRITE: begin
            case (ri)
              iatp_pkg::RegOrb: begin ifr_q <= clr_b(ifr_q, pcr_q); orb_q <= wd; end
              iatp_pkg::RegOra: begin ifr_q <= clr_a(ifr_q, pcr_q); ora_q <= wd; end
              iatp_pkg::RegOraNh: ora_q <= wd;
              iatp_pkg::RegDdrb: ddb_q <= wd;
              iatp_pkg::RegDdra: dda_q <= wd;
              iatp_pkg::RegT1cl, iatp_pkg::RegT1ll: l1_q[7:0] <= wd;
              iatp_pkg::RegT1ch: begin
                l1_q[15:8] <= wd;
                c1_q <= {1'b0, wd, l1_q[7:0]} + 17'd1;
                a1_q <= 1'b1;
                ifr_q <= ifr_q & ~FT1;
                pb7_q <= 1'b0;
              end
              iatp_pkg::RegT1lh: begin l1_q[15:8] <= wd; ifr_q <= ifr_q & ~FT1; end
              iatp_pkg::RegT2cl: l2_q[7:0] <= wd;
              iatp_pkg::RegT2ch: begin
                l2_q[15:8] <= wd;
                c2_q <= {1'b0, wd, l2_q[7:0]} + 17'd1;
                a2_q <= 1'b1;
                ifr_q <= ifr_q & ~FT2;
              end
              iatp_pkg::RegSr: begin sr_q <= wd; ifr_q <= ifr_q & ~FSr; end
              iatp_pkg::RegAcr: begin
                if (wd[7] && !acr_q[7]) pb7_q <= 1'b1;
                acr_q <= wd;
              end
              iatp_pkg::RegPcr: pcr_q <= wd;
              iatp_pkg::RegIfr: ifr_q <= ifr_q & ~wd[6:0];
              default: begin
                if (wd[7]) ier_q <= ier_q | wd[6:0];
                else ier_q <= ier_q & ~wd[6:0];
              end
            endcase
          end
          iatp_pkg::OP_TICK: begin
            if (cy != 8'd0) begin
              logic [6:0] f;
              f = ifr_q;
              if (a1_q) begin
                if (n17 < c1_q) c1_q <= c1_q - n17;
                else begin
                  f = f | FT1;
                  // free-running reload is finished by the modulo unit
                  if (!acr_q[6]) begin
                    a1_q <= 1'b0;
                    c1_q <= CntIdle;
                    if (acr_q[7]) pb7_q <= 1'b1;
                  end
                end
              end
              if (a2_q && !acr_q[5]) begin
                if (n17 < c2_q) c2_q <= c2_q - n17;
                else begin
                  c2_q <= CntIdle; a2_q <= 1'b0; f = f | FT2;
                end
              end
              ifr_q <= f;
            end
          end
          iatp_pkg::OP_PINS_A: pa_q <= pv;
          iatp_pkg::OP_PINS_B: begin
            pb_q <= pv;
            if (pb_q[6] && !pv[6] && acr_q[5] && a2_q) begin
              if (c2_q > 17'd1) c2_q <= c2_q - 17'd1;
              else begin c2_q <= CntIdle; a2_q <= 1'b0; ifr_q <= ifr_q | FT2; end
            end
          end
          iatp_pkg::OP_CA1: begin
            if (lines_q[0] != lv && lv == pcr_q[0]) ifr_q <= ifr_q | FCa1;
            lines_q[0] <= lv;
          end
          iatp_pkg::OP_CA2: begin
            if (!pcr_q[3] && lines_q[1] != lv && lv == pcr_q[2]) ifr_q <= ifr_q | FCa2;
            lines_q[1] <= lv;
          end
          iatp_pkg::OP_CB1: begin
            if (lines_q[2] != lv && lv == pcr_q[4]) ifr_q <= ifr_q | FCb1;
            lines_q[2] <= lv;
          end
          iatp_pkg::OP_CB2: begin
            if (!pcr_q[7] && lines_q[3] != lv && lv == pcr_q[6]) ifr_q <= ifr_q | FCb2;
            lines_q[3] <= lv;
          end
          default: ;
        endcase
      end
    end
  end

  logic [7:0] pbo;
  assign pbo = acr_q[7] ? {pb7_q, (orb_q[6:0] | ~ddb_q[6:0])} : (orb_q | ~ddb_q);
  assign out_word_o = {5'd0, chb_q, cha_q, pbo, (ora_q | ~dda_q),
                       |(ifr_q & ier_q), rd_q};
endmodule

/* rtl/iatp_checker.sv */
`include "assert_macros.svh"
module iatp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  `CHK_IMPL(a_excl, m_axis_tvalid, !s_axis_tready)
  `CHK_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `CHK_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `CHK_IMPL(a_pad, m_axis_tvalid, m_axis_tdata[31:27] == 5'd0)
endmodule

bind interface_adapter_timers_ports iatp_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
